### rtl/frdc_pkg.sv
package frdc_pkg;

  // Geometry and limits
  localparam int CHANNELS          = 8;
  localparam int WAYS              = 8;
  localparam int BLOCKS_PER_DIE    = 1024;
  localparam int PAGES_PER_BLOCK   = 256;
  localparam int MAX_BLOCKED_READS = 255;

  localparam int NUM_BLOCKS = CHANNELS * WAYS * BLOCKS_PER_DIE;
  localparam int IDX_W      = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
  localparam int PAGE_W     = $clog2(PAGES_PER_BLOCK + 1);
  localparam int CNT_W      = $clog2(MAX_BLOCKED_READS + 1);

  // Request field widths
  localparam int OP_W    = 2;
  localparam int MODE_W  = 2;
  localparam int CH_W    = 3;
  localparam int WAY_W   = 3;
  localparam int BLK_W   = 10;
  localparam int PG_W    = 8;
  localparam int PROGD_W = 9;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Operation codes
  localparam logic [OP_W-1:0] OP_READ  = 2'd0;
  localparam logic [OP_W-1:0] OP_WRITE = 2'd1;
  localparam logic [OP_W-1:0] OP_ERASE = 2'd2;

  // Check mode codes
  localparam logic [MODE_W-1:0] MODE_SELECT  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_RELEASE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_BUFBLK  = 2'd2;

  // Classified request, as queued for the back end
  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [MODE_W-1:0]  mode;
    logic [IDX_W-1:0]   idx;
    logic [PG_W-1:0]    page;
    logic [PROGD_W-1:0] progd;
    logic               ok;
  } frdc_req_t;

  // Per-block table entry
  typedef struct packed {
    logic [PAGE_W-1:0] ppage;
    logic [CNT_W-1:0]  rd_cnt;
    logic              erase_mark;
  } frdc_entry_t;

endpackage

### rtl/frdc_if.sv
interface frdc_req_if;
  logic                           valid;
  logic                           ready;
  logic [frdc_pkg::OP_W-1:0]      operation;
  logic [frdc_pkg::MODE_W-1:0]    check_mode;
  logic [frdc_pkg::CH_W-1:0]      channel;
  logic [frdc_pkg::WAY_W-1:0]     way;
  logic [frdc_pkg::BLK_W-1:0]     block_number;
  logic [frdc_pkg::PG_W-1:0]      page_number;
  logic [frdc_pkg::PROGD_W-1:0]   programmed_pages;

  modport source (output valid, operation, check_mode, channel, way, block_number,
                  page_number, programmed_pages, input ready);
  modport sink   (input valid, operation, check_mode, channel, way, block_number,
                  page_number, programmed_pages, output ready);
endinterface

interface frdc_rsp_if;
  logic valid;
  logic ready;
  logic pass;
  logic erase_release_needed;

  modport source (output valid, pass, erase_release_needed, input ready);
  modport sink   (input valid, pass, erase_release_needed, output ready);
endinterface

### rtl/frdc_front.sv
module frdc_front (
  frdc_req_if.sink              in_ch,
  input  logic                  clr_done,
  output logic                  push_valid,
  output frdc_pkg::frdc_req_t   push_data,
  input  logic                  push_ready
);

  logic op_ok;
  logic mode_ok;
  logic addr_ok;
  logic page_ok;

  // Decode codes and range-check the address
  always_comb begin
    op_ok   = (in_ch.operation == frdc_pkg::OP_READ) ||
              (in_ch.operation == frdc_pkg::OP_WRITE) ||
              (in_ch.operation == frdc_pkg::OP_ERASE);
    mode_ok = (in_ch.check_mode == frdc_pkg::MODE_SELECT) ||
              (in_ch.check_mode == frdc_pkg::MODE_RELEASE) ||
              (in_ch.check_mode == frdc_pkg::MODE_BUFBLK);
    addr_ok = (32'(in_ch.channel) < frdc_pkg::CHANNELS) &&
              (32'(in_ch.way) < frdc_pkg::WAYS) &&
              (32'(in_ch.block_number) < frdc_pkg::BLOCKS_PER_DIE);
    page_ok = (in_ch.operation == frdc_pkg::OP_ERASE) ||
              (32'(in_ch.page_number) < frdc_pkg::PAGES_PER_BLOCK);
  end

  // Build the queued word; flat block index from channel, way, block
  always_comb begin
    push_data.op    = in_ch.operation;
    push_data.mode  = in_ch.check_mode;
    push_data.idx   = frdc_pkg::IDX_W'((32'(in_ch.channel) * frdc_pkg::WAYS +
                      32'(in_ch.way)) * frdc_pkg::BLOCKS_PER_DIE +
                      32'(in_ch.block_number));
    push_data.page  = in_ch.page_number;
    push_data.progd = in_ch.programmed_pages;
    push_data.ok    = op_ok && mode_ok && addr_ok && page_ok;
  end

  // No words taken while the table is being cleared
  assign push_valid  = in_ch.valid && clr_done;
  assign in_ch.ready = push_ready && clr_done;

endmodule

### rtl/frdc_queue.sv
module frdc_queue (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          push_valid,
  input  frdc_pkg::frdc_req_t           push_data,
  output logic                          push_ready,
  output logic                          pop_valid,
  output frdc_pkg::frdc_req_t           pop_data,
  input  logic                          pop_ready,
  output logic [frdc_pkg::QCNT_W-1:0]   level
);

  frdc_pkg::frdc_req_t                slot_r [frdc_pkg::QUEUE_DEPTH];
  logic [frdc_pkg::QPTR_W-1:0]        wr_ptr_r, wr_ptr_nxt;
  logic [frdc_pkg::QPTR_W-1:0]        rd_ptr_r, rd_ptr_nxt;
  logic [frdc_pkg::QCNT_W-1:0]        cnt_r, cnt_nxt;
  logic                               do_push;
  logic                               do_pop;

  assign push_ready = (cnt_r != frdc_pkg::QCNT_W'(frdc_pkg::QUEUE_DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_data   = slot_r[rd_ptr_r];
  assign level      = cnt_r;
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Pointer and fill bookkeeping
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == frdc_pkg::QPTR_W'(frdc_pkg::QUEUE_DEPTH - 1)) ?
                   '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == frdc_pkg::QPTR_W'(frdc_pkg::QUEUE_DEPTH - 1)) ?
                   '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!do_push && do_pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Payload storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

### rtl/frdc_back.sv
module frdc_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  pop_valid,
  input  frdc_pkg::frdc_req_t   pop_data,
  output logic                  pop_ready,
  output logic                  clr_done,
  frdc_rsp_if.source            out_ch
);

  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_IDLE  = 3'b010,
    ST_EXEC  = 3'b100
  } state_t;

  state_t                         state_r, state_nxt;
  logic [frdc_pkg::IDX_W-1:0]     clr_cnt_r, clr_cnt_nxt;
  frdc_pkg::frdc_req_t            cur_r;
  frdc_pkg::frdc_entry_t          rd_q_r;
  frdc_pkg::frdc_entry_t          mem [frdc_pkg::NUM_BLOCKS];
  frdc_pkg::frdc_entry_t          new_entry;
  logic                           res_pass;
  logic                           res_flag;
  logic                           below;
  logic                           finish;
  logic                           rd_en;
  logic                           wr_en;
  logic                           fwd;
  logic                           out_valid_r, out_valid_nxt;
  logic                           pass_r;
  logic                           flag_r;
  logic [frdc_pkg::CNT_W-1:0]     cnt_up;

  // Table update and result for the word held in EXEC
  always_comb begin
    new_entry = rd_q_r;
    res_pass  = 1'b0;
    res_flag  = 1'b0;
    below     = frdc_pkg::PAGE_W'(cur_r.page) < rd_q_r.ppage;
    cnt_up    = (32'(rd_q_r.rd_cnt) < frdc_pkg::MAX_BLOCKED_READS) ?
                rd_q_r.rd_cnt + 1'b1 : rd_q_r.rd_cnt;
    case (cur_r.op)
      frdc_pkg::OP_READ: begin
        case (cur_r.mode)
          frdc_pkg::MODE_SELECT: begin
            res_flag = rd_q_r.erase_mark;
            if (below) begin
              res_pass = 1'b1;
            end else begin
              new_entry.rd_cnt = cnt_up;
            end
          end
          frdc_pkg::MODE_RELEASE: begin
            if (below) begin
              res_pass = 1'b1;
              if (rd_q_r.rd_cnt != '0) begin
                new_entry.rd_cnt = rd_q_r.rd_cnt - 1'b1;
              end
            end
          end
          default: begin
            res_flag         = rd_q_r.erase_mark;
            new_entry.rd_cnt = cnt_up;
          end
        endcase
      end
      frdc_pkg::OP_WRITE: begin
        if (cur_r.mode != frdc_pkg::MODE_BUFBLK &&
            frdc_pkg::PAGE_W'(cur_r.page) == rd_q_r.ppage) begin
          new_entry.ppage = rd_q_r.ppage + 1'b1;
          res_pass        = 1'b1;
        end
      end
      default: begin
        // erase
        if (cur_r.mode == frdc_pkg::MODE_BUFBLK) begin
          new_entry.erase_mark = 1'b1;
        end else if (32'(rd_q_r.ppage) == 32'(cur_r.progd) && rd_q_r.rd_cnt == '0) begin
          new_entry.ppage      = '0;
          new_entry.erase_mark = 1'b0;
          res_pass             = 1'b1;
        end else if (cur_r.mode == frdc_pkg::MODE_SELECT) begin
          new_entry.erase_mark = 1'b1;
        end
      end
    endcase
    if (!cur_r.ok) begin
      res_pass = 1'b0;
      res_flag = 1'b0;
    end
  end

  // Sequencer: clear sweep, then fetch / execute with back-to-back fetch
  always_comb begin
    state_nxt   = state_r;
    clr_cnt_nxt = clr_cnt_r;
    finish      = 1'b0;
    pop_ready   = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == frdc_pkg::IDX_W'(frdc_pkg::NUM_BLOCKS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        pop_ready = 1'b1;
        if (pop_valid) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (!out_valid_r || out_ch.ready) begin
          finish    = 1'b1;
          pop_ready = 1'b1;
          state_nxt = pop_valid ? ST_EXEC : ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  assign rd_en    = pop_ready && pop_valid;
  assign wr_en    = finish && cur_r.ok;
  assign fwd      = wr_en && (pop_data.idx == cur_r.idx);
  assign clr_done = (state_r != ST_CLEAR);

  // Output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (finish) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      cur_r <= pop_data;
    end
    if (finish) begin
      pass_r <= res_pass;
      flag_r <= res_flag;
    end
  end

  // Block table: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (state_r == ST_CLEAR) begin
      mem[clr_cnt_r] <= '0;
    end else if (wr_en) begin
      mem[cur_r.idx] <= new_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_q_r <= fwd ? new_entry : mem[pop_data.idx];
    end
  end

  assign out_ch.valid                = out_valid_r;
  assign out_ch.pass                 = pass_r;
  assign out_ch.erase_release_needed = flag_r;

endmodule

### rtl/flash_row_address_dependency_check_unit.sv
// Channel   Dir  Handshake    Word
// in_ch     in   valid/ready  operation, check_mode, channel, way, block_number,
//                             page_number, programmed_pages
// out_ch    out  valid/ready  pass, erase_release_needed
//
// Each request costs one table read and one write-back. The read of the next
// word overlaps the write-back of the current one, with a bypass for the same
// block, so while words are queued and no result is stalled, the back end
// retires one word per cycle. A word goes from a queue slot to cur_r and its
// table entry in EXEC, then to the output register. After reset, in_ch.ready is
// low while the table is zeroed, one entry per cycle, NUM_BLOCKS (65536) in all.
// A two-word queue lets the input side keep accepting while a result waits.
module flash_row_address_dependency_check_unit (
  input  logic        clk,
  input  logic        rst_n,
  frdc_req_if.sink    in_ch,
  frdc_rsp_if.source  out_ch
);

  logic                               q_push_valid;
  frdc_pkg::frdc_req_t                q_push_data;
  logic                               q_push_ready;
  logic                               q_pop_valid;
  frdc_pkg::frdc_req_t                q_pop_data;
  logic                               q_pop_ready;
  logic [frdc_pkg::QCNT_W-1:0]        q_level;
  logic                               clr_done;

  frdc_front u_front (
    .in_ch      (in_ch),
    .clr_done   (clr_done),
    .push_valid (q_push_valid),
    .push_data  (q_push_data),
    .push_ready (q_push_ready)
  );

  frdc_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (q_push_valid),
    .push_data  (q_push_data),
    .push_ready (q_push_ready),
    .pop_valid  (q_pop_valid),
    .pop_data   (q_pop_data),
    .pop_ready  (q_pop_ready),
    .level      (q_level)
  );

  frdc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (q_pop_valid),
    .pop_data  (q_pop_data),
    .pop_ready (q_pop_ready),
    .clr_done  (clr_done),
    .out_ch    (out_ch)
  );

  // Once the clear sweep ends it never restarts without reset
  a_clear_once: assert property (@(posedge clk) disable iff (!rst_n)
    !$fell(clr_done))
    else $error("table clear restarted");

  // No word enters while the table is being swept
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    !clr_done |-> !(in_ch.valid && in_ch.ready))
    else $error("word accepted during table clear");

  // Queue fill never exceeds its depth
  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(q_level) <= frdc_pkg::QUEUE_DEPTH)
    else $error("queue overflow");

  // Nothing is queued before the sweep has finished
  a_queue_empty_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    !clr_done |=> (q_level == '0) || $past(clr_done))
    else $error("queue filled during table clear");

endmodule
